>>> sv/spct_pkg.sv
// Shared types and constants for the shape pair contact tracker.
package spct_pkg;

   localparam int ID_BITS = 6;

   localparam logic KIND_CIRCLE = 1'b0;
   localparam logic KIND_BOX    = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = QPTR_BITS + 1;

   typedef enum logic [1:0] {
      EV_ENTER = 2'd0,
      EV_STAY  = 2'd1,
      EV_EXIT  = 2'd2
   } event_kind_type;

   typedef struct packed {
      logic                kind_a;
      logic                kind_b;
      logic [ID_BITS-1:0]  id_a;
      logic [ID_BITS-1:0]  id_b;
      logic signed [15:0]  pos_ax;
      logic signed [15:0]  pos_ay;
      logic [15:0]         size_a;
      logic [15:0]         height_a;
      logic signed [15:0]  pos_bx;
      logic signed [15:0]  pos_by;
      logic [15:0]         size_b;
      logic [15:0]         height_b;
   } req_type;

   typedef struct packed {
      logic [ID_BITS-1:0] event_self;
      logic [ID_BITS-1:0] event_other;
      event_kind_type     event_kind;
      logic               last_event;
   } rsp_type;

   // Overlap verdict for one pair, circle first.
   typedef struct packed {
      logic               touch;
      logic [ID_BITS-1:0] p;
      logic [ID_BITS-1:0] q;
   } pair_hit_type;

   typedef struct packed {
      logic [QCNT_BITS-1:0] count;
      logic                 pop;
   } queue_status_type;

endpackage

>>> sv/spct_ram.sv
// Generic RAM: one write port, two registered read ports.
module spct_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> sv/spct_geom.sv
// Overlap test pipeline: swap, differences and clamp, squares, compare.
module spct_geom import spct_pkg::*; #(
   parameter int MAX_COLLIDERS = 64,
   parameter int COORD_BITS    = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         hold,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type      req_data,
   output logic         t_valid,
   input  logic         t_take,
   output pair_hit_type t_data
);

   localparam int W  = COORD_BITS;
   localparam int WH = COORD_BITS + 2;
   localparam int WQ = 2 * COORD_BITS + 2;

   typedef enum logic [1:0] {
      PAIR_CC,
      PAIR_CB,
      PAIR_BB
   } pair_code_type;

   typedef struct packed {
      pair_code_type      code;
      logic [W-1:0]       ax;
      logic [W-1:0]       ay;
      logic [W-1:0]       bx;
      logic [W-1:0]       by;
      logic [WH-1:0]      ahx;
      logic [WH-1:0]      ahy;
      logic [WH-1:0]      bhx;
      logic [WH-1:0]      bhy;
      logic [W:0]         rsum;
      logic [W-1:0]       rad;
      logic [ID_BITS-1:0] p;
      logic [ID_BITS-1:0] q;
   } s1_type;

   typedef struct packed {
      logic               is_bb;
      logic               bb_hit;
      logic [W:0]         mx;
      logic [W:0]         my;
      logic [W:0]         mr;
      logic [ID_BITS-1:0] p;
      logic [ID_BITS-1:0] q;
   } s2_type;

   typedef struct packed {
      logic               is_bb;
      logic               bb_hit;
      logic [WQ-1:0]      sqx;
      logic [WQ-1:0]      sqy;
      logic [WQ-1:0]      sqr;
      logic [ID_BITS-1:0] p;
      logic [ID_BITS-1:0] q;
   } s3_type;

   req_type      s0_ff;
   logic         s0_valid_ff, s0_valid_in;
   s1_type       s1_ff, s1_in;
   logic         s1_valid_ff, s1_valid_in;
   s2_type       s2_ff, s2_in;
   logic         s2_valid_ff, s2_valid_in;
   s3_type       s3_ff, s3_in;
   logic         s3_valid_ff, s3_valid_in;
   pair_hit_type t_ff, t_in;
   logic         t_valid_ff, t_valid_in;

   logic s0_free, s1_free, s2_free, s3_free, t_free;
   logic req_accept;

   assign t_free  = !t_valid_ff || t_take;
   assign s3_free = !s3_valid_ff || t_free;
   assign s2_free = !s2_valid_ff || s3_free;
   assign s1_free = !s1_valid_ff || s2_free;
   assign s0_free = !s0_valid_ff || s1_free;

   assign req_stall  = hold || !s0_free;
   assign req_accept = req_valid && !req_stall;

   // Stage 0: put the circle first, form box extents and radius sum.
   logic                 swap, ka, kb, id_ok;
   logic [15:0]          f_x, f_y, f_w, f_h, g_x, g_y, g_w, g_h;
   logic signed [W-1:0]  s0_ax, s0_ay, s0_bx, s0_by;
   logic [W-1:0]         aw, ah, bw, bh;
   logic signed [WH-1:0] ahx, ahy, bhx, bhy;

   always_comb begin
      swap = (s0_ff.kind_a == KIND_BOX) && (s0_ff.kind_b == KIND_CIRCLE);
      ka   = swap ? s0_ff.kind_b : s0_ff.kind_a;
      kb   = swap ? s0_ff.kind_a : s0_ff.kind_b;
      f_x  = swap ? s0_ff.pos_bx   : s0_ff.pos_ax;
      f_y  = swap ? s0_ff.pos_by   : s0_ff.pos_ay;
      f_w  = swap ? s0_ff.size_b   : s0_ff.size_a;
      f_h  = swap ? s0_ff.height_b : s0_ff.height_a;
      g_x  = swap ? s0_ff.pos_ax   : s0_ff.pos_bx;
      g_y  = swap ? s0_ff.pos_ay   : s0_ff.pos_by;
      g_w  = swap ? s0_ff.size_a   : s0_ff.size_b;
      g_h  = swap ? s0_ff.height_a : s0_ff.height_b;
      s0_ax = W'(f_x);
      s0_ay = W'(f_y);
      s0_bx = W'(g_x);
      s0_by = W'(g_y);
      aw    = W'(f_w);
      ah    = W'(f_h);
      bw    = W'(g_w);
      bh    = W'(g_h);
      ahx   = s0_ax + $signed({1'b0, aw});
      ahy   = s0_ay + $signed({1'b0, ah});
      bhx   = s0_bx + $signed({1'b0, bw});
      bhy   = s0_by + $signed({1'b0, bh});
      id_ok = (32'(s0_ff.id_a) < MAX_COLLIDERS) && (32'(s0_ff.id_b) < MAX_COLLIDERS);

      if (!ka && !kb) begin
         s1_in.code = PAIR_CC;
      end else if (ka && kb) begin
         s1_in.code = PAIR_BB;
      end else begin
         s1_in.code = PAIR_CB;
      end
      s1_in.ax   = s0_ax;
      s1_in.ay   = s0_ay;
      s1_in.bx   = s0_bx;
      s1_in.by   = s0_by;
      s1_in.ahx  = ahx;
      s1_in.ahy  = ahy;
      s1_in.bhx  = bhx;
      s1_in.bhy  = bhy;
      s1_in.rsum = {1'b0, aw} + {1'b0, bw};
      s1_in.rad  = aw;
      s1_in.p    = swap ? s0_ff.id_b : s0_ff.id_a;
      s1_in.q    = swap ? s0_ff.id_a : s0_ff.id_b;
   end

   // Stage 1: distance magnitudes (clamped for circle-box), box overlap.
   logic signed [W-1:0]  ax, ay, bx, by;
   logic signed [WH-1:0] s1_ahx, s1_ahy, s1_bhx, s1_bhy;
   logic signed [W:0]    ccdx, ccdy, lox, loy;
   logic signed [WH-1:0] hix, hiy;
   logic [W:0]           ccmx, ccmy, cbmx, cbmy;

   always_comb begin
      ax     = s1_ff.ax;
      ay     = s1_ff.ay;
      bx     = s1_ff.bx;
      by     = s1_ff.by;
      s1_ahx = s1_ff.ahx;
      s1_ahy = s1_ff.ahy;
      s1_bhx = s1_ff.bhx;
      s1_bhy = s1_ff.bhy;
      ccdx   = ax - bx;
      ccdy   = ay - by;
      lox    = bx - ax;
      loy    = by - ay;
      hix    = ax - s1_bhx;
      hiy    = ay - s1_bhy;
      ccmx   = ccdx[W] ? $unsigned(-ccdx) : $unsigned(ccdx);
      ccmy   = ccdy[W] ? $unsigned(-ccdy) : $unsigned(ccdy);

      if (ax < bx) begin
         cbmx = $unsigned(lox);
      end else if (ax > s1_bhx) begin
         cbmx = (W+1)'($unsigned(hix));
      end else begin
         cbmx = '0;
      end
      if (ay < by) begin
         cbmy = $unsigned(loy);
      end else if (ay > s1_bhy) begin
         cbmy = (W+1)'($unsigned(hiy));
      end else begin
         cbmy = '0;
      end

      s2_in.is_bb  = (s1_ff.code == PAIR_BB);
      s2_in.bb_hit = (s1_ahx > bx) && (ax < s1_bhx) && (s1_ahy > by) && (ay < s1_bhy);
      s2_in.p      = s1_ff.p;
      s2_in.q      = s1_ff.q;
      case (s1_ff.code)
         PAIR_CC: begin
            s2_in.mx = ccmx;
            s2_in.my = ccmy;
            s2_in.mr = s1_ff.rsum;
         end
         PAIR_CB: begin
            s2_in.mx = cbmx;
            s2_in.my = cbmy;
            s2_in.mr = {1'b0, s1_ff.rad};
         end
         default: begin
            s2_in.mx = '0;
            s2_in.my = '0;
            s2_in.mr = '0;
         end
      endcase
   end

   // Stage 2: squares.
   always_comb begin
      s3_in.is_bb  = s2_ff.is_bb;
      s3_in.bb_hit = s2_ff.bb_hit;
      s3_in.sqx    = WQ'(s2_ff.mx) * WQ'(s2_ff.mx);
      s3_in.sqy    = WQ'(s2_ff.my) * WQ'(s2_ff.my);
      s3_in.sqr    = WQ'(s2_ff.mr) * WQ'(s2_ff.mr);
      s3_in.p      = s2_ff.p;
      s3_in.q      = s2_ff.q;
   end

   // Stage 3: strict compare of squared distance against squared radius.
   logic [WQ:0] sqsum;

   always_comb begin
      sqsum      = {1'b0, s3_ff.sqx} + {1'b0, s3_ff.sqy};
      t_in.touch = s3_ff.is_bb ? s3_ff.bb_hit : (sqsum < {1'b0, s3_ff.sqr});
      t_in.p     = s3_ff.p;
      t_in.q     = s3_ff.q;
   end

   always_comb begin
      s0_valid_in = s0_free ? req_accept : s0_valid_ff;
      s1_valid_in = s1_free ? (s0_valid_ff && id_ok) : s1_valid_ff;
      s2_valid_in = s2_free ? s1_valid_ff : s2_valid_ff;
      s3_valid_in = s3_free ? s2_valid_ff : s3_valid_ff;
      t_valid_in  = t_free ? s3_valid_ff : t_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         t_valid_ff  <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         t_valid_ff  <= t_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s0_ff <= req_data;
      end
      if (s1_free) begin
         s1_ff <= s1_in;
      end
      if (s2_free) begin
         s2_ff <= s2_in;
      end
      if (s3_free) begin
         s3_ff <= s3_in;
      end
      if (t_free) begin
         t_ff <= t_in;
      end
   end

   assign t_valid = t_valid_ff;
   assign t_data  = t_ff;

endmodule

>>> sv/spct_contact.sv
// Contact bit sequencer: clear pass, bit lookup, event decision, bit update.
module spct_contact import spct_pkg::*; #(
   parameter int MAX_COLLIDERS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             t_valid,
   output logic             t_take,
   input  pair_hit_type     t_data,
   input  queue_status_type q_status,
   output logic             push,
   output rsp_type          push_data,
   output logic             clearing
);

   localparam int DEPTH = MAX_COLLIDERS * MAX_COLLIDERS;
   localparam int AW    = $clog2(DEPTH);

   typedef struct packed {
      logic               touch;
      logic [ID_BITS-1:0] p;
      logic [ID_BITS-1:0] q;
      logic [AW-1:0]      aqp;
      logic [AW-1:0]      apq;
   } e1_type;

   typedef struct packed {
      logic               touch;
      logic               emit;
      event_kind_type     kind;
      logic [ID_BITS-1:0] p;
      logic [ID_BITS-1:0] q;
      logic [AW-1:0]      apq;
   } e2_type;

   logic          clear_active_ff, clear_active_in;
   logic [AW-1:0] clear_addr_ff, clear_addr_in;
   logic          e1_valid_ff, e1_valid_in;
   e1_type        e1_ff, e1_in;
   logic          e2_valid_ff, e2_valid_in;
   e2_type        e2_ff, e2_in;
   logic          lw_valid_ff, lw_valid_in;
   logic [AW-1:0] lw_addr_ff, lw_addr_in;
   logic          lw_data_ff, lw_data_in;

   logic          wr_en, wr_data;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] addr_qp, addr_pq;
   logic          rd_qp, rd_pq;
   logic          credit_ok;

   assign addr_qp = AW'(t_data.q) * AW'(MAX_COLLIDERS) + AW'(t_data.p);
   assign addr_pq = AW'(t_data.p) * AW'(MAX_COLLIDERS) + AW'(t_data.q);

   spct_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_bits (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (addr_qp),
      .rd_addr_b (addr_pq),
      .rd_data_a (rd_qp),
      .rd_data_b (rd_pq)
   );

   // Room for both events of a pair, assuming no drain in the meantime.
   assign credit_ok = QCNT_BITS'(q_status.count + QCNT_BITS'(e2_valid_ff)
                      - QCNT_BITS'(q_status.pop)) <= QCNT_BITS'(QUEUE_DEPTH - 2);
   assign t_take    = t_valid && !clear_active_ff && !e1_valid_ff && credit_ok;

   always_comb begin
      clear_active_in = clear_active_ff;
      clear_addr_in   = clear_addr_ff;
      if (clear_active_ff) begin
         if (clear_addr_ff == AW'(DEPTH - 1)) begin
            clear_active_in = 1'b0;
         end else begin
            clear_addr_in = clear_addr_ff + 1'b1;
         end
      end
   end

   // Bit decisions for both halves of the pair.
   logic bqp, bpq, bpq_eff, same;
   logic emit0, emit1;
   event_kind_type kind0, kind1;

   always_comb begin
      bqp     = (lw_valid_ff && lw_addr_ff == e1_ff.aqp) ? lw_data_ff : rd_qp;
      bpq     = (lw_valid_ff && lw_addr_ff == e1_ff.apq) ? lw_data_ff : rd_pq;
      same    = (e1_ff.p == e1_ff.q);
      bpq_eff = same ? e1_ff.touch : bpq;
      if (e1_ff.touch) begin
         emit0 = 1'b1;
         kind0 = bqp ? EV_STAY : EV_ENTER;
         emit1 = 1'b1;
         kind1 = bpq_eff ? EV_STAY : EV_ENTER;
      end else begin
         emit0 = bqp;
         kind0 = EV_EXIT;
         emit1 = bpq_eff;
         kind1 = EV_EXIT;
      end
   end

   always_comb begin
      e1_valid_in = t_take;
      e1_in.touch = t_data.touch;
      e1_in.p     = t_data.p;
      e1_in.q     = t_data.q;
      e1_in.aqp   = addr_qp;
      e1_in.apq   = addr_pq;

      e2_valid_in = e1_valid_ff;
      e2_in.touch = e1_ff.touch;
      e2_in.emit  = emit1;
      e2_in.kind  = kind1;
      e2_in.p     = e1_ff.p;
      e2_in.q     = e1_ff.q;
      e2_in.apq   = e1_ff.apq;
   end

   // One bit write a cycle: clear pass, then first half, then second half.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = e1_ff.aqp;
      wr_data = e1_ff.touch;
      if (clear_active_ff) begin
         wr_en   = 1'b1;
         wr_addr = clear_addr_ff;
         wr_data = 1'b0;
      end else if (e1_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = e1_ff.aqp;
         wr_data = e1_ff.touch;
      end else if (e2_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = e2_ff.apq;
         wr_data = e2_ff.touch;
      end
      lw_valid_in = wr_en;
      lw_addr_in  = wr_addr;
      lw_data_in  = wr_data;
   end

   always_comb begin
      push                  = 1'b0;
      push_data.event_self  = e1_ff.p;
      push_data.event_other = e1_ff.q;
      push_data.event_kind  = kind0;
      push_data.last_event  = !emit1;
      if (e1_valid_ff) begin
         push = emit0;
      end else if (e2_valid_ff) begin
         push                  = e2_ff.emit;
         push_data.event_self  = e2_ff.q;
         push_data.event_other = e2_ff.p;
         push_data.event_kind  = e2_ff.kind;
         push_data.last_event  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_active_ff <= 1'b1;
         clear_addr_ff   <= '0;
         e1_valid_ff     <= 1'b0;
         e2_valid_ff     <= 1'b0;
         lw_valid_ff     <= 1'b0;
      end else begin
         clear_active_ff <= clear_active_in;
         clear_addr_ff   <= clear_addr_in;
         e1_valid_ff     <= e1_valid_in;
         e2_valid_ff     <= e2_valid_in;
         lw_valid_ff     <= lw_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (t_take) begin
         e1_ff <= e1_in;
      end
      e2_ff      <= e2_in;
      lw_addr_ff <= lw_addr_in;
      lw_data_ff <= lw_data_in;
   end

   assign clearing = clear_active_ff;

endmodule

>>> sv/spct_evq.sv
// Event output queue with registered entries.
module spct_evq import spct_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rsp_type          push_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   output queue_status_type status
);

   rsp_type              ent_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = ent_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign status.count = count_ff;
   assign status.pop   = pop;

endmodule

>>> sv/shape_pair_contact_tracker.sv
// Top level of the shape pair contact tracker.
// Order: a request passes the geometry registers s0, s1, s2, s3 and t; the sequencer's
//   e1 stage then pushes the first event into the output queue and its e2 stage the second.
// Pairs never enter the sequencer back to back: the single write port of the contact
//   bit RAM takes one bit update for each half of the pair.
// Reset: synchronous; afterwards a clearing pass over all MAX_COLLIDERS*MAX_COLLIDERS
//   contact bits zeroes them while req_stall stays high.
module shape_pair_contact_tracker import spct_pkg::*; #(
   parameter int MAX_COLLIDERS = 64,
   parameter int COORD_BITS    = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Geometry verdict handed to the contact sequencer.
   logic         t_valid;
   logic         t_take;
   pair_hit_type t_data;

   // Events headed for the output queue, and the queue's fill for credit.
   logic             push;
   rsp_type          push_data;
   queue_status_type q_status;

   // High while the contact bits are being zeroed after reset.
   logic clearing;

   // Swap box-circle pairs, then test overlap over four register stages:
   // extents, clamped magnitudes, squares, strict compare.
   spct_geom #(
      .MAX_COLLIDERS (MAX_COLLIDERS),
      .COORD_BITS    (COORD_BITS)
   ) u_geom (
      .clock     (clock),
      .reset     (reset),
      .hold      (clearing),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .t_valid   (t_valid),
      .t_take    (t_take),
      .t_data    (t_data)
   );

   // Look up both directed contact bits at once, decide enter, stay or exit
   // for each collider, then write the two bits back on consecutive cycles.
   spct_contact #(
      .MAX_COLLIDERS (MAX_COLLIDERS)
   ) u_contact (
      .clock     (clock),
      .reset     (reset),
      .t_valid   (t_valid),
      .t_take    (t_take),
      .t_data    (t_data),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data),
      .clearing  (clearing)
   );

   // Hold finished events until the consumer takes them; the sequencer only
   // starts a pair when both of its events are sure to fit.
   spct_evq u_evq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .status    (q_status)
   );

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the shape pair contact tracker: directed pairs, then random contact sequences.
module testbench;
   import spct_pkg::*;

   localparam int ITEMS       = 1700;   // rough size of the random part
   localparam int MAX_GAP     = 10;     // longest per-transaction idle on either side
   localparam int LONG_HOLD   = 300;    // receiver hold-off that backs the block up
   localparam int QUIET_LIMIT = 20000;  // covers the post-reset clearing pass many times
   localparam int TAIL_CYCLES = 32;     // covers the latency of pairs with no events
   localparam int SHOWN_MAX   = 100;

   // One shape of a pair, widened so that sums and squares stay exact.
   typedef struct {
      logic               kind;
      logic [ID_BITS-1:0] id;
      longint             x, y, w, h;
   } shape_type;

   // One directed stimulus row; count < 0 means the predictor supplies the events.
   typedef struct {
      req_type pair;
      int      count;
      rsp_type ev [2];
   } row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rsp_type due_events [$];      // events still owed by the block, oldest first
   bit      contact_map [64][64];
   row_type directed_rows [$];

   int errors        = 0;
   int sent          = 0;
   int quiet_cycles  = 0;
   int send_max      = MAX_GAP;
   int rcv_max       = MAX_GAP;
   int burst_left    = 0;
   bit hold_now      = 1'b0;
   int swapped_pairs = 0;
   int self_pairs    = 0;
   int got_enter     = 0;
   int got_stay      = 0;
   int got_exit      = 0;

   shape_pair_contact_tracker u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Contact predictor
   // ------------------------------------------------------------------

   function automatic shape_type unpack_shape(logic kind, logic [ID_BITS-1:0] id,
                                              logic [15:0] x, logic [15:0] y,
                                              logic [15:0] w, logic [15:0] h);
      shape_type s;
      s.kind = kind;
      s.id   = id;
      s.x    = longint'($signed(x));
      s.y    = longint'($signed(y));
      s.w    = longint'(w);
      s.h    = longint'(h);
      return s;
   endfunction

   function automatic bit closer_than(longint dx, longint dy, longint r);
      return dx * dx + dy * dy < r * r;
   endfunction

   // Strict overlap test; a mixed pair arrives with the circle as p.
   function automatic bit shapes_touch(shape_type p, shape_type q);
      longint cx, cy;
      if (p.kind == KIND_CIRCLE && q.kind == KIND_CIRCLE)
         return closer_than(p.x - q.x, p.y - q.y, p.w + q.w);
      if (p.kind == KIND_BOX && q.kind == KIND_BOX)
         return p.x + p.w > q.x && p.x < q.x + q.w &&
                p.y + p.h > q.y && p.y < q.y + q.h;
      // Clamp the centre onto the box to find its closest point.
      cx = p.x;
      cy = p.y;
      if (p.x < q.x) cx = q.x;
      else if (p.x > q.x + q.w) cx = q.x + q.w;
      if (p.y < q.y) cy = q.y;
      else if (p.y > q.y + q.h) cy = q.y + q.h;
      return closer_than(p.x - cx, p.y - cy, p.w);
   endfunction

   // Advance the contact map by one pair and return the events it raises.
   function automatic int step_contacts(req_type r, output rsp_type ev [2]);
      shape_type          a, b, t;
      logic [ID_BITS-1:0] p, q;
      bit                 hit;
      int                 n;
      n = 0;
      ev[0] = '0;
      ev[1] = '0;
      a = unpack_shape(r.kind_a, r.id_a, r.pos_ax, r.pos_ay, r.size_a, r.height_a);
      b = unpack_shape(r.kind_b, r.id_b, r.pos_bx, r.pos_by, r.size_b, r.height_b);
      // Put the circle first when a box leads a mixed pair.
      if (a.kind == KIND_BOX && b.kind == KIND_CIRCLE) begin
         t = a;
         a = b;
         b = t;
         swapped_pairs++;
      end
      if (a.id == b.id) self_pairs++;
      p = a.id;
      q = b.id;
      hit = shapes_touch(a, b);
      // First member: bit [q][p]. Update before the second member looks, so a
      // self pair sees its own update.
      if (hit || contact_map[q][p]) begin
         ev[n].event_self  = p;
         ev[n].event_other = q;
         ev[n].event_kind  = !hit ? EV_EXIT : (contact_map[q][p] ? EV_STAY : EV_ENTER);
         contact_map[q][p] = hit;
         n++;
      end
      if (hit || contact_map[p][q]) begin
         ev[n].event_self  = q;
         ev[n].event_other = p;
         ev[n].event_kind  = !hit ? EV_EXIT : (contact_map[p][q] ? EV_STAY : EV_ENTER);
         contact_map[p][q] = hit;
         n++;
      end
      if (n > 0) ev[n-1].last_event = 1'b1;
      return n;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic req_type pair_of(logic ka, logic kb, int ia, int ib,
                                       int ax, int ay, int sa, int ha,
                                       int bx, int by, int sb, int hb);
      req_type r;
      r.kind_a   = ka;
      r.kind_b   = kb;
      r.id_a     = ID_BITS'(ia);
      r.id_b     = ID_BITS'(ib);
      r.pos_ax   = 16'(ax);
      r.pos_ay   = 16'(ay);
      r.size_a   = 16'(sa);
      r.height_a = 16'(ha);
      r.pos_bx   = 16'(bx);
      r.pos_by   = 16'(by);
      r.size_b   = 16'(sb);
      r.height_b = 16'(hb);
      return r;
   endfunction

   function automatic rsp_type event_of(int self_id, int other_id,
                                        event_kind_type kind, logic last);
      rsp_type e;
      e.event_self  = ID_BITS'(self_id);
      e.event_other = ID_BITS'(other_id);
      e.event_kind  = kind;
      e.last_event  = last;
      return e;
   endfunction

   function automatic void add_row(req_type pair, int count,
                                   rsp_type e0 = '0, rsp_type e1 = '0);
      row_type row;
      row.pair  = pair;
      row.count = count;
      row.ev[0] = e0;
      row.ev[1] = e1;
      directed_rows.push_back(row);
   endfunction

   // Nearby shapes with small ids, so contacts build up and get revisited.
   function automatic req_type local_pair();
      req_type r;
      int      ax, ay;
      ax = int'($urandom_range(2000, 0)) - 1000;
      ay = int'($urandom_range(2000, 0)) - 1000;
      r = pair_of($urandom_range(1, 0), $urandom_range(1, 0),
                  $urandom_range(7, 0), $urandom_range(7, 0),
                  ax, ay, $urandom_range(160, 0), $urandom_range(160, 0),
                  ax + int'($urandom_range(400, 0)) - 200,
                  ay + int'($urandom_range(400, 0)) - 200,
                  $urandom_range(160, 0), $urandom_range(160, 0));
      // Circle heights are ignored; fill them with anything.
      if (r.kind_a == KIND_CIRCLE) r.height_a = 16'($urandom);
      if (r.kind_b == KIND_CIRCLE) r.height_b = 16'($urandom);
      return r;
   endfunction

   function automatic req_type wild_pair();
      return pair_of($urandom_range(1, 0), $urandom_range(1, 0),
                     $urandom_range(63, 0), $urandom_range(63, 0),
                     $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
   endfunction

   // Hold req_valid until the block takes the transaction; return on that edge.
   task automatic offer_pair(req_type pair, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= pair;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   // Drop valid and wait until every owed event has come back.
   task automatic drain_pause();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_events.size() != 0) @(posedge clock);
   endtask

   task automatic issue_pair(req_type pair);
      rsp_type ev [2];
      int      n;
      int      gap;
      // Re-draw the idle pattern now and then, including stretches with none.
      if (sent % 100 == 0) begin
         send_max = ($urandom_range(3, 0) == 0) ? 0 : MAX_GAP;
         rcv_max  = ($urandom_range(3, 0) == 0) ? 0 : MAX_GAP;
      end
      // Back up the block: long receiver hold while the sender keeps pushing.
      if (sent == 600) begin
         hold_now   = 1'b1;
         burst_left = 40;
      end
      if (sent == 1100) drain_pause();
      gap = (burst_left > 0) ? 0 : $urandom_range(send_max, 0);
      if (burst_left > 0) burst_left--;
      offer_pair(pair, gap);
      n = step_contacts(pair, ev);
      for (int k = 0; k < n; k++) due_events.push_back(ev[k]);
      sent++;
   endtask

   // Slide the second shape across the first: approach, touch, stay, leave.
   task automatic run_contact_sequence();
      req_type pair;
      int      steps, span, ax, ay, slope;
      bit      along_x;
      pair    = local_pair();
      steps   = $urandom_range(12, 4);
      span    = $urandom_range(320, 60);
      slope   = int'($urandom_range(40, 0)) - 20;
      along_x = $urandom_range(1, 0);
      ax      = int'($signed(pair.pos_ax));
      ay      = int'($signed(pair.pos_ay));
      pair.size_a = 16'($urandom_range(160, 24));
      pair.size_b = 16'($urandom_range(160, 24));
      for (int k = 0; k < steps; k++) begin
         if (along_x) begin
            pair.pos_bx = 16'(ax - span + k * 2 * span / (steps - 1));
            pair.pos_by = 16'(ay + k * slope);
         end else begin
            pair.pos_by = 16'(ay - span + k * 2 * span / (steps - 1));
            pair.pos_bx = 16'(ax + k * slope);
         end
         issue_pair(pair);
      end
   endtask

   task automatic report(string what);
      errors++;
      if (errors <= SHOWN_MAX) $display("%0t: mismatch: %s", $time, what);
   endtask

   // ------------------------------------------------------------------
   // Event checker and watchdog
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         case (rsp_data.event_kind)
            EV_ENTER: got_enter++;
            EV_STAY:  got_stay++;
            EV_EXIT:  got_exit++;
            default: ;
         endcase
         if (due_events.size() == 0) begin
            report($sformatf("unexpected event self=%0d other=%0d kind=%0d",
                             rsp_data.event_self, rsp_data.event_other,
                             rsp_data.event_kind));
         end else begin
            want = due_events.pop_front();
            if (rsp_data.event_self !== want.event_self)
               report($sformatf("event_self got %0d want %0d",
                                rsp_data.event_self, want.event_self));
            if (rsp_data.event_other !== want.event_other)
               report($sformatf("event_other got %0d want %0d",
                                rsp_data.event_other, want.event_other));
            if (rsp_data.event_kind !== want.event_kind)
               report($sformatf("event_kind got %0d want %0d",
                                rsp_data.event_kind, want.event_kind));
            if (rsp_data.last_event !== want.last_event)
               report($sformatf("last_event got %0d want %0d",
                                rsp_data.last_event, want.last_event));
         end
      end
      // Count cycles where neither channel moves a transaction.
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no transaction for %0d cycles, %0d events owed",
                  QUIET_LIMIT, due_events.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random stall before each event, one long hold on request
   // ------------------------------------------------------------------

   initial begin
      int hold;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_now) begin
            hold_now = 1'b0;
            hold     = LONG_HOLD;
         end else begin
            hold = $urandom_range(rcv_max, 0);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
      end
   end

   // ------------------------------------------------------------------
   // Sender: directed rows, then random contact sequences and noise
   // ------------------------------------------------------------------

   initial begin
      rsp_type ev [2];
      int      n;
      req_valid <= 1'b0;
      req_data  <= '0;
      reset     <= 1'b1;

      // Circle pair: enter, stay, stay in swapped order, tangent exit, then nothing.
      add_row(pair_of(KIND_CIRCLE, KIND_CIRCLE, 1, 2, 0, 0, 32, 0, 40, 0, 16, 0), 2,
              event_of(1, 2, EV_ENTER, 0), event_of(2, 1, EV_ENTER, 1));
      add_row(pair_of(KIND_CIRCLE, KIND_CIRCLE, 1, 2, 0, 0, 32, 0, 40, 0, 16, 0), 2,
              event_of(1, 2, EV_STAY, 0), event_of(2, 1, EV_STAY, 1));
      add_row(pair_of(KIND_CIRCLE, KIND_CIRCLE, 2, 1, 40, 0, 16, 0, 0, 0, 32, 0), 2,
              event_of(2, 1, EV_STAY, 0), event_of(1, 2, EV_STAY, 1));
      add_row(pair_of(KIND_CIRCLE, KIND_CIRCLE, 1, 2, 0, 0, 32, 0, 48, 0, 16, 0), 2,
              event_of(1, 2, EV_EXIT, 0), event_of(2, 1, EV_EXIT, 1));
      add_row(pair_of(KIND_CIRCLE, KIND_CIRCLE, 1, 2, 0, 0, 32, 0, 48, 0, 16, 0), 0);
      // Same collider on both sides: enter then stay, and a single exit.
      add_row(pair_of(KIND_CIRCLE, KIND_CIRCLE, 5, 5, 0, 0, 16, 0, 0, 0, 16, 0), 2,
              event_of(5, 5, EV_ENTER, 0), event_of(5, 5, EV_STAY, 1));
      add_row(pair_of(KIND_CIRCLE, KIND_CIRCLE, 5, 5, 0, 0, 16, 0, 100, 0, 16, 0), 1,
              event_of(5, 5, EV_EXIT, 1));
      // Boxes: overlap, then edges that only meet.
      add_row(pair_of(KIND_BOX, KIND_BOX, 10, 11, 0, 0, 32, 32, 16, 16, 32, 32), 2,
              event_of(10, 11, EV_ENTER, 0), event_of(11, 10, EV_ENTER, 1));
      add_row(pair_of(KIND_BOX, KIND_BOX, 10, 11, 0, 0, 32, 32, 32, 0, 32, 32), 2,
              event_of(10, 11, EV_EXIT, 0), event_of(11, 10, EV_EXIT, 1));
      // Box before circle: the circle's events lead.
      add_row(pair_of(KIND_BOX, KIND_CIRCLE, 20, 21, 0, 0, 64, 64, 80, 32, 32, 0), 2,
              event_of(21, 20, EV_ENTER, 0), event_of(20, 21, EV_ENTER, 1));
      add_row(pair_of(KIND_CIRCLE, KIND_BOX, 21, 20, 200, 32, 32, 0, 0, 0, 64, 64), 2,
              event_of(21, 20, EV_EXIT, 0), event_of(20, 21, EV_EXIT, 1));
      // Zero radius inside a box, and zero width boxes.
      add_row(pair_of(KIND_CIRCLE, KIND_BOX, 30, 31, 10, 10, 0, 0, 0, 0, 64, 64), 0);
      add_row(pair_of(KIND_BOX, KIND_BOX, 32, 33, 0, 0, 0, 64, -16, 0, 64, 64), -1);
      add_row(pair_of(KIND_BOX, KIND_BOX, 34, 35, -16, 0, 64, 64, 0, 0, 0, 64), -1);
      // Field extremes.
      add_row(pair_of(KIND_CIRCLE, KIND_CIRCLE, 63, 0, -32768, -32768, 65535, 65535,
                      32767, 32767, 65535, 65535), 2,
              event_of(63, 0, EV_ENTER, 0), event_of(0, 63, EV_ENTER, 1));
      add_row(pair_of(KIND_CIRCLE, KIND_CIRCLE, 63, 0, -32768, -32768, 0, 0,
                      32767, 32767, 0, 0), 2,
              event_of(63, 0, EV_EXIT, 0), event_of(0, 63, EV_EXIT, 1));
      add_row(pair_of(KIND_BOX, KIND_BOX, 62, 61, 32767, 32767, 65535, 65535,
                      -32768, -32768, 65535, 65535), 0);
      add_row(pair_of(KIND_BOX, KIND_BOX, 7, 8, -32768, -32768, 65535, 65535,
                      0, 0, 1, 1), -1);
      // Circle against box side: tangent, then one unit closer.
      add_row(pair_of(KIND_CIRCLE, KIND_BOX, 40, 41, 0, 0, 16, 0, 16, -8, 32, 16), 0);
      add_row(pair_of(KIND_CIRCLE, KIND_BOX, 40, 41, 0, 0, 17, 0, 16, -8, 32, 16), 2,
              event_of(40, 41, EV_ENTER, 0), event_of(41, 40, EV_ENTER, 1));
      add_row(pair_of(KIND_CIRCLE, KIND_BOX, 40, 41, 60, 20, 30, 0, 16, -8, 32, 16), -1);
      add_row(pair_of(KIND_BOX, KIND_CIRCLE, 41, 40, -100, -100, 50, 50,
                      -40, -40, 20, 777), -1);
      add_row(pair_of(KIND_CIRCLE, KIND_CIRCLE, 3, 4, 100, -100, 10, 65535,
                      110, -95, 1, 43690), -1);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed rows; typed rows carry their own events but still
      // advance the predictor's contact map.
      foreach (directed_rows[i]) begin
         offer_pair(directed_rows[i].pair, $urandom_range(MAX_GAP, 0));
         n = step_contacts(directed_rows[i].pair, ev);
         if (directed_rows[i].count >= 0) begin
            for (int k = 0; k < directed_rows[i].count; k++)
               due_events.push_back(directed_rows[i].ev[k]);
         end else begin
            for (int k = 0; k < n; k++) due_events.push_back(ev[k]);
         end
      end
      drain_pause();

      // Mostly well-formed contact sequences; the rest nearby or wild noise.
      while (sent < ITEMS) begin
         if ($urandom_range(3, 0) != 0) run_contact_sequence();
         else if ($urandom_range(1, 0) != 0) issue_pair(local_pair());
         else issue_pair(wild_pair());
      end
      req_valid <= 1'b0;

      while (due_events.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d pairs (%0d directed), %0d box-first swaps, %0d self pairs",
               sent + directed_rows.size(), directed_rows.size(), swapped_pairs, self_pairs);
      $display("events seen: %0d enter, %0d stay, %0d exit; %0d mismatches",
               got_enter, got_stay, got_exit, errors);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
